// File: hdl/lfu_pkg.sv
// Shared types and constants for the LFU indexed min-heap unit.
package lfu_pkg;

	localparam int CAPACITY   = 64;
	localparam int PAGE_BITS  = 10;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS   = $clog2(CAPACITY);
	localparam int SIZE_BITS  = IDX_BITS + 1;
	localparam int PAGE_SPAN  = 1 << PAGE_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [SIZE_BITS-1:0]  FULL_SIZE = SIZE_BITS'(CAPACITY);

	typedef enum logic [1:0] {
		KIND_INSERT  = 2'd0,
		KIND_INCR    = 2'd1,
		KIND_EXTRACT = 2'd2,
		KIND_PROBE   = 2'd3
	} op_kind_t;

	typedef enum logic [2:0] {
		ST_INCREMENTED = 3'd0,
		ST_INSERTED    = 3'd1,
		ST_NOT_FOUND   = 3'd2,
		ST_EMPTY       = 3'd3,
		ST_FULL        = 3'd4,
		ST_PRESENT     = 3'd5
	} status_t;

	typedef struct packed {
		logic [PAGE_BITS-1:0]  page;
		logic [COUNT_BITS-1:0] count;
	} heap_entry_t;

	typedef struct packed {
		logic                valid;
		logic [IDX_BITS-1:0] idx;
	} pos_entry_t;

endpackage

// File: hdl/lfu_req_if.sv
// Request channel: one operation word per handshake.
interface lfu_req_if
	import lfu_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [1:0]            kind;
	logic [PAGE_BITS-1:0]  page;
	logic [COUNT_BITS-1:0] init_count;

	modport source (output valid, kind, page, init_count, input ready);
	modport sink   (input valid, kind, page, init_count, output ready);
endinterface

// File: hdl/lfu_rsp_if.sv
// Response channel: one result word per handshake.
interface lfu_rsp_if
	import lfu_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [2:0]            status;
	logic [PAGE_BITS-1:0]  page_out;
	logic [COUNT_BITS-1:0] count_out;
	logic [SIZE_BITS-1:0]  occupancy;
	logic [PAGE_BITS-1:0]  least_page;
	logic [COUNT_BITS-1:0] least_count;

	modport source (output valid, status, page_out, count_out, occupancy, least_page,
		least_count, input ready);
	modport sink   (input valid, status, page_out, count_out, occupancy, least_page,
		least_count, output ready);
endinterface

// File: hdl/lfu_indexed_min_heap_unit.sv
// LFU indexed min-heap unit: heap memory, position memory and sequencer.
//
// Usage: req carries one operation word (kind, page, init_count); rsp returns
// one result word per request with status, extracted entry, occupancy and the
// entry at the root afterwards. Words move when valid and ready are both high.
// One request is worked on at a time; every step is a read or a write of the
// heap memory, which has separate read and write addresses and registered read data.
// An increment lifts its entry to the root, sifts the last entry down from the
// root and then climbs again with the page's new count.
// After reset the position memory is swept clear, one page a cycle, across all
// 1024 pages; req.ready stays low until the sweep ends.
// The result sits in an output register: a stalled receiver holds it, and
// the next request is taken and worked on meanwhile, finishing only once the
// register is free.
module lfu_indexed_min_heap_unit
	import lfu_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	lfu_req_if.sink  req,
	lfu_rsp_if.source rsp
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_LOOKUP, S_EXT, S_BUMP, S_LIFT, S_LIFT_WR,
		S_DN_LOAD, S_DN_L, S_DN_R, S_DN_CMP, S_DN_DONE,
		S_UP_CHK, S_UP_CMP, S_ROOT, S_ROOT_RD, S_OUT
	} state_t;

	state_t                state_q;
	logic [PAGE_BITS-1:0]  clr_cnt_q;
	op_kind_t              kind_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [COUNT_BITS-1:0] init_q;
	logic [COUNT_BITS-1:0] newcnt_q;
	logic [SIZE_BITS-1:0]  size_q;
	logic [IDX_BITS-1:0]   idx_q;
	heap_entry_t           cur_q;
	heap_entry_t           left_q;
	heap_entry_t           least_q;
	logic                  has_right_q;
	logic                  bump_q;
	status_t               status_q;
	logic [PAGE_BITS-1:0]  pout_q;
	logic [COUNT_BITS-1:0] cout_q;

	logic                  rsp_valid_q;
	status_t               rsp_status_q;
	logic [PAGE_BITS-1:0]  rsp_pout_q;
	logic [COUNT_BITS-1:0] rsp_cout_q;
	logic [SIZE_BITS-1:0]  rsp_occ_q;
	heap_entry_t           rsp_least_q;

	heap_entry_t heap_mem [CAPACITY];
	pos_entry_t  pos_mem  [PAGE_SPAN];
	heap_entry_t heap_rdata_q;
	pos_entry_t  pos_rdata_q;

	logic                  heap_we;
	logic [IDX_BITS-1:0]   heap_wa;
	heap_entry_t           heap_wd;
	logic [IDX_BITS-1:0]   heap_ra;
	logic                  pos_we;
	logic [PAGE_BITS-1:0]  pos_wa;
	pos_entry_t            pos_wd;
	logic [PAGE_BITS-1:0]  pos_ra;

	logic [IDX_BITS-1:0]   parent;
	logic [SIZE_BITS-1:0]  lidx;
	logic [SIZE_BITS:0]    ridx;
	logic                  l_in;
	logic                  r_in;
	logic [SIZE_BITS-1:0]  size_m1;
	logic                  take_left;
	logic                  take_right;
	logic [COUNT_BITS-1:0] min_cnt;
	logic                  up_move;
	logic                  out_free;
	op_kind_t              req_kind;

	assign parent     = (idx_q - IDX_BITS'(1)) >> 1;
	assign lidx       = {idx_q, 1'b1};
	assign ridx       = {1'b0, lidx} + (SIZE_BITS+1)'(1);
	assign l_in       = lidx < size_q;
	assign r_in       = ridx < {1'b0, size_q};
	assign size_m1    = size_q - SIZE_BITS'(1);
	assign take_left  = left_q.count < cur_q.count;
	assign min_cnt    = take_left ? left_q.count : cur_q.count;
	assign take_right = has_right_q && (heap_rdata_q.count < min_cnt);
	assign up_move    = heap_rdata_q.count > cur_q.count;
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign req_kind   = op_kind_t'(req.kind);

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.page_out    = rsp_pout_q;
	assign rsp.count_out   = rsp_cout_q;
	assign rsp.occupancy   = rsp_occ_q;
	assign rsp.least_page  = rsp_least_q.page;
	assign rsp.least_count = rsp_least_q.count;

	always_comb begin
		heap_we = 1'b0;
		heap_wa = idx_q;
		heap_wd = cur_q;
		heap_ra = '0;
		pos_we  = 1'b0;
		pos_wa  = cur_q.page;
		pos_wd  = '{valid: 1'b1, idx: idx_q};
		pos_ra  = req.page;
		case (state_q)
			S_CLEAR: begin
				pos_we = 1'b1;
				pos_wa = clr_cnt_q;
				pos_wd = '0;
			end
			S_LOOKUP: begin
				if (kind_q == KIND_INSERT || kind_q == KIND_INCR)
					heap_ra = pos_rdata_q.idx;
			end
			S_EXT: begin
				pos_we  = 1'b1;
				pos_wa  = heap_rdata_q.page;
				pos_wd  = '0;
				heap_ra = size_m1[IDX_BITS-1:0];
			end
			S_LIFT: begin
				heap_ra = (idx_q != '0) ? parent : size_m1[IDX_BITS-1:0];
			end
			S_LIFT_WR: begin
				heap_we = 1'b1;
				heap_wd = heap_rdata_q;
				pos_we  = 1'b1;
				pos_wa  = heap_rdata_q.page;
			end
			S_DN_L: begin
				if (l_in) begin
					heap_ra = lidx[IDX_BITS-1:0];
				end else begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
				end
			end
			S_DN_R: begin
				heap_ra = ridx[IDX_BITS-1:0];
			end
			S_DN_CMP: begin
				heap_we = 1'b1;
				pos_we  = 1'b1;
				if (take_right) begin
					heap_wd = heap_rdata_q;
					pos_wa  = heap_rdata_q.page;
				end else if (take_left) begin
					heap_wd = left_q;
					pos_wa  = left_q.page;
				end
			end
			S_UP_CHK: begin
				if (idx_q == '0) begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
				end else begin
					heap_ra = parent;
				end
			end
			S_UP_CMP: begin
				heap_we = 1'b1;
				pos_we  = 1'b1;
				if (up_move) begin
					heap_wd = heap_rdata_q;
					pos_wa  = heap_rdata_q.page;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (heap_we)
			heap_mem[heap_wa] <= heap_wd;
		heap_rdata_q <= heap_mem[heap_ra];
	end

	always_ff @(posedge clk) begin
		if (pos_we)
			pos_mem[pos_wa] <= pos_wd;
		pos_rdata_q <= pos_mem[pos_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			size_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + PAGE_BITS'(1);
					if (clr_cnt_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						kind_q  <= req_kind;
						page_q  <= req.page;
						init_q  <= req.init_count;
						pout_q  <= '0;
						cout_q  <= '0;
						bump_q  <= 1'b0;
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					case (kind_q)
						KIND_PROBE: begin
							status_q <= pos_rdata_q.valid ? ST_PRESENT : ST_NOT_FOUND;
							state_q  <= S_ROOT;
						end
						KIND_EXTRACT: begin
							if (size_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_ROOT;
							end else begin
								status_q <= ST_PRESENT;
								state_q  <= S_EXT;
							end
						end
						default: begin
							if (pos_rdata_q.valid) begin
								status_q <= ST_INCREMENTED;
								bump_q   <= 1'b1;
								idx_q    <= pos_rdata_q.idx;
								state_q  <= S_BUMP;
							end else if (kind_q == KIND_INCR) begin
								status_q <= ST_NOT_FOUND;
								state_q  <= S_ROOT;
							end else if (size_q >= FULL_SIZE) begin
								status_q <= ST_FULL;
								state_q  <= S_ROOT;
							end else begin
								status_q <= ST_INSERTED;
								cur_q    <= '{page: page_q, count: init_q};
								idx_q    <= size_q[IDX_BITS-1:0];
								size_q   <= size_q + SIZE_BITS'(1);
								state_q  <= S_UP_CHK;
							end
						end
					endcase
				end
				S_EXT: begin
					pout_q <= heap_rdata_q.page;
					cout_q <= heap_rdata_q.count;
					size_q <= size_m1;
					state_q <= (size_q == SIZE_BITS'(1)) ? S_ROOT : S_DN_LOAD;
				end
				S_BUMP: begin
					newcnt_q <= (heap_rdata_q.count == COUNT_MAX) ? COUNT_MAX
						: heap_rdata_q.count + COUNT_BITS'(1);
					state_q  <= S_LIFT;
				end
				S_LIFT: begin
					if (idx_q != '0) begin
						state_q <= S_LIFT_WR;
					end else if (size_q == SIZE_BITS'(1)) begin
						cur_q   <= '{page: page_q, count: newcnt_q};
						state_q <= S_UP_CHK;
					end else begin
						size_q  <= size_m1;
						state_q <= S_DN_LOAD;
					end
				end
				S_LIFT_WR: begin
					idx_q   <= parent;
					state_q <= S_LIFT;
				end
				S_DN_LOAD: begin
					cur_q   <= heap_rdata_q;
					idx_q   <= '0;
					state_q <= S_DN_L;
				end
				S_DN_L: begin
					state_q <= l_in ? S_DN_R : S_DN_DONE;
				end
				S_DN_R: begin
					left_q      <= heap_rdata_q;
					has_right_q <= r_in;
					state_q     <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (take_right) begin
						idx_q   <= ridx[IDX_BITS-1:0];
						state_q <= S_DN_L;
					end else if (take_left) begin
						idx_q   <= lidx[IDX_BITS-1:0];
						state_q <= S_DN_L;
					end else begin
						state_q <= S_DN_DONE;
					end
				end
				S_DN_DONE: begin
					if (bump_q) begin
						cur_q   <= '{page: page_q, count: newcnt_q};
						idx_q   <= size_q[IDX_BITS-1:0];
						size_q  <= size_q + SIZE_BITS'(1);
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_ROOT;
					end
				end
				S_UP_CHK: begin
					state_q <= (idx_q == '0) ? S_ROOT : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (up_move) begin
						idx_q   <= parent;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (size_q == '0) begin
						least_q <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_ROOT_RD;
					end
				end
				S_ROOT_RD: begin
					least_q <= heap_rdata_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						rsp_status_q <= status_q;
						rsp_pout_q   <= pout_q;
						rsp_cout_q   <= cout_q;
						rsp_occ_q    <= size_q;
						rsp_least_q  <= least_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sim/tb_lfu_indexed_min_heap_unit.sv
// Testbench for the LFU indexed min-heap unit: directed and random operations checked against a heap predictor.
`timescale 1ns / 100ps
module tb_lfu_indexed_min_heap_unit;
	import lfu_pkg::*;

	typedef struct {
		logic [2:0]            status;
		logic [PAGE_BITS-1:0]  page_out;
		logic [COUNT_BITS-1:0] count_out;
		logic [SIZE_BITS-1:0]  occupancy;
		logic [PAGE_BITS-1:0]  least_page;
		logic [COUNT_BITS-1:0] least_count;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	lfu_req_if req ();
	lfu_rsp_if rsp ();

	lfu_indexed_min_heap_unit DUT (.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source));

	always #4 clk = ~clk;

	logic [PAGE_BITS-1:0]  hp_page [CAPACITY];
	logic [COUNT_BITS-1:0] hp_count [CAPACITY];
	int                    slot_of [PAGE_SPAN];
	bit                    resident [PAGE_SPAN];
	int                    heap_fill;
	result_word_t          pending_results [$];
	int                    error_count;
	int                    results_seen;
	logic [PAGE_BITS-1:0]  hot_pages [16];

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %0s at result %0d: got %0d want %0d", what, results_seen, got, want);
		error_count++;
	endtask

	function automatic void swap_slots(int a, int b);
		logic [PAGE_BITS-1:0]  tp;
		logic [COUNT_BITS-1:0] tc;
		tp = hp_page[a];
		tc = hp_count[a];
		hp_page[a] = hp_page[b];
		hp_count[a] = hp_count[b];
		hp_page[b] = tp;
		hp_count[b] = tc;
		slot_of[hp_page[a]] = a;
		slot_of[hp_page[b]] = b;
	endfunction

	function automatic void drop_root();
		int i;
		int l;
		int s;
		resident[hp_page[0]] = 0;
		heap_fill--;
		if (heap_fill > 0) begin
			hp_page[0] = hp_page[heap_fill];
			hp_count[0] = hp_count[heap_fill];
			slot_of[hp_page[0]] = 0;
			i = 0;
			forever begin
				l = 2 * i + 1;
				s = i;
				if (l < heap_fill && hp_count[l] < hp_count[s]) s = l;
				if (l + 1 < heap_fill && hp_count[l + 1] < hp_count[s]) s = l + 1;
				if (s == i) break;
				swap_slots(s, i);
				i = s;
			end
		end
	endfunction

	function automatic void push_entry(logic [PAGE_BITS-1:0] pg, logic [COUNT_BITS-1:0] cnt);
		int i;
		i = heap_fill++;
		hp_page[i] = pg;
		hp_count[i] = cnt;
		slot_of[pg] = i;
		resident[pg] = 1;
		while (i > 0 && hp_count[(i - 1) / 2] > cnt) begin
			swap_slots(i, (i - 1) / 2);
			i = (i - 1) / 2;
		end
	endfunction

	function automatic void bump_use(logic [PAGE_BITS-1:0] pg);
		int loc;
		logic [COUNT_BITS-1:0] cnt;
		loc = slot_of[pg];
		cnt = hp_count[loc];
		while (loc > 0) begin
			swap_slots(loc, (loc - 1) / 2);
			loc = (loc - 1) / 2;
		end
		drop_root();
		push_entry(pg, cnt == COUNT_MAX ? cnt : cnt + COUNT_BITS'(1));
	endfunction

	function automatic result_word_t predict_heap_op(op_kind_t kind, logic [PAGE_BITS-1:0] pg,
			logic [COUNT_BITS-1:0] init);
		result_word_t r;
		r.status = ST_NOT_FOUND;
		r.page_out = '0;
		r.count_out = '0;
		case (kind)
			KIND_INSERT: begin
				if (resident[pg]) begin
					bump_use(pg);
					r.status = ST_INCREMENTED;
				end else if (heap_fill >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					push_entry(pg, init);
					r.status = ST_INSERTED;
				end
			end
			KIND_INCR: begin
				if (resident[pg]) begin
					bump_use(pg);
					r.status = ST_INCREMENTED;
				end
			end
			KIND_EXTRACT: begin
				if (heap_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.page_out = hp_page[0];
					r.count_out = hp_count[0];
					drop_root();
					r.status = ST_PRESENT;
				end
			end
			default: r.status = resident[pg] ? ST_PRESENT : ST_NOT_FOUND;
		endcase
		r.occupancy = SIZE_BITS'(heap_fill);
		r.least_page = (heap_fill != 0) ? hp_page[0] : '0;
		r.least_count = (heap_fill != 0) ? hp_count[0] : '0;
		return r;
	endfunction

	task automatic send_word(op_kind_t kind, logic [PAGE_BITS-1:0] pg, logic [COUNT_BITS-1:0] init);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.page <= pg;
		req.init_count <= init;
		do @(posedge clk); while (!req.ready);
		pending_results = {pending_results, predict_heap_op(kind, pg, init)};
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		result_word_t w;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				w = pending_results.pop_front();
				if (rsp.status !== w.status) report_mismatch("status", rsp.status, w.status);
				if (rsp.page_out !== w.page_out)
					report_mismatch("page_out", rsp.page_out, w.page_out);
				if (rsp.count_out !== w.count_out)
					report_mismatch("count_out", rsp.count_out, w.count_out);
				if (rsp.occupancy !== w.occupancy)
					report_mismatch("occupancy", rsp.occupancy, w.occupancy);
				if (rsp.least_page !== w.least_page)
					report_mismatch("least_page", rsp.least_page, w.least_page);
				if (rsp.least_count !== w.least_count)
					report_mismatch("least_count", rsp.least_count, w.least_count);
			end
			results_seen++;
		end
	end

	// receiver stall: draw a hold for every word
	initial begin
		int hold;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
			if (hold != 0) begin
				rsp.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	task automatic test_directed();
		send_word(KIND_EXTRACT, 10'h3FF, 16'hFFFF);
		send_word(KIND_PROBE, 10'd0, 16'd0);
		send_word(KIND_INCR, 10'd5, 16'd0);
		send_word(KIND_INSERT, 10'd0, 16'hFFFF);
		send_word(KIND_INSERT, 10'h3FF, 16'd0);
		send_word(KIND_INSERT, 10'h155, 16'h5555);
		send_word(KIND_INSERT, 10'h2AA, 16'hAAAA);
		send_word(KIND_INSERT, 10'd0, 16'd0);
		send_word(KIND_INCR, 10'h3FF, 16'd0);
		send_word(KIND_PROBE, 10'h3FF, 16'd0);
		send_word(KIND_PROBE, 10'd7, 16'd0);
		send_word(KIND_INSERT, 10'd9, 16'hFFFE);
		send_word(KIND_INCR, 10'd9, 16'd0);
		send_word(KIND_INCR, 10'd9, 16'd0);
		send_word(KIND_INCR, 10'd9, 16'd0);
		repeat (6) send_word(KIND_EXTRACT, 10'd0, 16'd0);
	endtask

	task automatic test_full_heap();
		for (int i = 0; i < CAPACITY + 2; i++)
			send_word(KIND_INSERT, 10'(100 + i), 16'($urandom_range(0, 7)));
		send_word(KIND_INSERT, 10'd1000, 16'd1);
		send_word(KIND_INCR, 10'(100 + $urandom_range(0, CAPACITY - 1)), 16'd0);
		wait_drained();
		repeat (CAPACITY + 1) send_word(KIND_EXTRACT, 10'd0, 16'd0);
	endtask

	task automatic test_random_mix();
		int sel;
		op_kind_t k;
		logic [PAGE_BITS-1:0] pg;
		foreach (hot_pages[i]) hot_pages[i] = 10'($urandom);
		for (int n = 0; n < 1050; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) k = KIND_INSERT;
			else if (sel < 65) k = KIND_INCR;
			else if (sel < 85) k = KIND_EXTRACT;
			else k = KIND_PROBE;
			pg = $urandom_range(0, 3) == 0 ? 10'($urandom) : hot_pages[$urandom_range(0, 15)];
			if (k == KIND_INCR && heap_fill > 0 && $urandom_range(0, 1))
				pg = hp_page[$urandom_range(0, heap_fill - 1)];
			send_word(k, pg, $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6)));
			if (n == 500) wait_drained();
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.kind = KIND_INSERT;
		req.page = '0;
		req.init_count = '0;
		error_count = 0;
		results_seen = 0;
		heap_fill = 0;
		foreach (resident[i]) resident[i] = 0;
		foreach (slot_of[i]) slot_of[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_heap();
		test_random_mix();
		wait_drained();
		repeat (100) @(posedge clk);
		if (error_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end
endmodule
